// ===== rtl/rtd_r2t_pkg.sv =====
`timescale 1ns / 1ps
package rtd_r2t_pkg;

    localparam int WORD_W    = 16;
    localparam int CODE_W    = 15;
    localparam int CFG_W     = 20;
    localparam int CFG_IDX_W = 1;
    localparam int TEMP_W    = 18;
    localparam int NUM_W     = 35;
    localparam int DIV_W     = 32;
    localparam int DREM_W    = 20;
    localparam int X_W       = 31;
    localparam int QF        = 28;
    localparam int PROD_W    = 60;
    localparam int ACC_W     = 34;
    localparam int SQ_ARG_W  = 54;
    localparam int SQ_W      = 56;
    localparam int ROOT_W    = 27;
    localparam int TERM_W    = 38;
    localparam int QDIV_SH   = 35;
    localparam int PDIV_SH   = 39;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_R_NOMINAL   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_R_REFERENCE = 1'd1;

    localparam logic [CFG_W-1:0] R_NOMINAL_RST   = 20'd10000;
    localparam logic [CFG_W-1:0] R_REFERENCE_RST = 20'd43000;

    // inverse callendar-van dusen constants
    localparam logic [TERM_W-1:0] CVD_A2_E16 = 38'd152748088900;
    localparam logic [ROOT_W-1:0] CVD_A_S8   = 27'd100052480;
    localparam logic [26:0]       SCALE_1E8  = 27'd100000000;
    localparam logic [7:0]        CVD_4B     = 8'd231;
    localparam logic [DIV_W-1:0]  ROUND_BIAS = 32'd3696;
    localparam logic [DIV_W-1:0]  HALF_1E5   = 32'd50000;

    // reciprocals for the constant divides, exact for dividends below 2^27
    localparam logic [27:0] RECIP_231  = 28'd148743457;   // ceil(2^35 / 231)
    localparam logic [27:0] RECIP_3125 = 28'd175921861;   // ceil(2^39 / 3125)

    localparam logic [2:0] POLY_LAST = 3'd5;

    localparam logic signed [TEMP_W-1:0] TEMP_MIN = -18'sd25000;
    localparam logic signed [TEMP_W-1:0] TEMP_MAX = 18'sd100000;

    typedef struct packed {
        logic             fault;
        logic [NUM_W-1:0] num;
    } q_entry_t;

    typedef struct packed {
        logic              start;
        logic [DREM_W-1:0] rem0;
        logic [DIV_W-1:0]  dividend;
        logic [DREM_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic                start;
        logic [SQ_ARG_W-1:0] arg;
    } sqrt_req_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RANGE,
        ST_DIV_X,
        ST_BRANCH,
        ST_Q_TERM,
        ST_SQRT,
        ST_DIV_Q,
        ST_Q_QUOT,
        ST_P_MUL,
        ST_P_ADD,
        ST_P_ROUND,
        ST_DIV_P,
        ST_P_QUOT,
        ST_DONE
    } bk_state_t;

    // horner coefficients, highest power first
    function automatic logic signed [ACC_W-1:0] poly_coef(input logic [2:0] idx);
        logic signed [ACC_W-1:0] c;
        case (idx)
            3'd0:    c = 34'sd1524300;
            3'd1:    c = -34'sd2818300;
            3'd2:    c = -34'sd48260000;
            3'd3:    c = 34'sd258590000;
            3'd4:    c = 34'sd2222800000;
            3'd5:    c = -34'sd2420200000;
            default: c = '0;
        endcase
        return c;
    endfunction

    function automatic logic signed [TEMP_W-1:0] clamp_temp(input logic signed [ACC_W-1:0] v);
        logic signed [TEMP_W-1:0] r;
        if (v < -34'sd25000) begin
            r = TEMP_MIN;
        end else if (v > 34'sd100000) begin
            r = TEMP_MAX;
        end else begin
            r = v[TEMP_W-1:0];
        end
        return r;
    endfunction

endpackage

// ===== rtl/rtd_resistance_to_temperature.sv =====
`timescale 1ns / 1ps
// channel   direction  handshake              payload
// s_*       in         s_valid / s_ready      s_rtd_word[15:0]
// m_*       out        m_valid / m_ready      m_temperature_centi[17:0] signed, m_fault
// cfg_*     in         cfg_valid / cfg_ready  cfg_index[0], cfg_data[19:0]
//
// the back end passes a fault item or a ratio of 8 or more straight to its done step; other
// items go through the radix-4 ratio divider, then the polynomial path or the square root
// unit and the quadratic path
// a two-item queue takes new items while the back end works and a result waits
// synchronous active-low reset clears control and loads the register defaults
// m_ready low holds the finished result; the back end waits in its done step
module rtd_resistance_to_temperature (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic [rtd_r2t_pkg::WORD_W-1:0]        s_rtd_word,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic signed [rtd_r2t_pkg::TEMP_W-1:0] m_temperature_centi,
    output logic                                  m_fault,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [rtd_r2t_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [rtd_r2t_pkg::CFG_W-1:0]         cfg_data
);
    import rtd_r2t_pkg::*;

    // configuration registers
    logic [CFG_W-1:0] r_nominal_reg;
    logic [CFG_W-1:0] r_reference_reg;

    // queue between front and back
    logic     q_valid;
    logic     q_pop;
    q_entry_t q_entry;

    // shared arithmetic units
    div_req_t          div_req;
    logic              div_done;
    logic [DIV_W-1:0]  div_quot;
    sqrt_req_t         sqrt_req;
    logic              sqrt_done;
    logic [ROOT_W-1:0] sqrt_root;

    // writes are always taken
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            r_nominal_reg   <= R_NOMINAL_RST;
            r_reference_reg <= R_REFERENCE_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_R_NOMINAL:   r_nominal_reg   <= cfg_data;
                CFG_R_REFERENCE: r_reference_reg <= cfg_data;
                default:         r_nominal_reg   <= r_nominal_reg;
            endcase
        end
    end

    // front: classify fault, form code * r_reference, queue the item
    rtd_r2t_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_rtd_word    (s_rtd_word),
        .r_reference_i (r_reference_reg),
        .pop_i         (q_pop),
        .q_valid_o     (q_valid),
        .q_entry_o     (q_entry)
    );

    // ratio division x = num * 2^13 / r_nominal
    rtd_r2t_divider u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req_i   (div_req),
        .done_o  (div_done),
        .quot_o  (div_quot)
    );

    // root of the quadratic discriminant
    rtd_r2t_sqrt u_sqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req_i   (sqrt_req),
        .done_o  (sqrt_done),
        .root_o  (sqrt_root)
    );

    // back: sequencer picks quadratic or polynomial branch, drives the result register
    rtd_r2t_back u_back (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .q_valid_i           (q_valid),
        .q_entry_i           (q_entry),
        .q_pop_o             (q_pop),
        .r_nominal_i         (r_nominal_reg),
        .div_req_o           (div_req),
        .div_done_i          (div_done),
        .div_quot_i          (div_quot),
        .sqrt_req_o          (sqrt_req),
        .sqrt_done_i         (sqrt_done),
        .sqrt_root_i         (sqrt_root),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_temperature_centi (m_temperature_centi),
        .m_fault             (m_fault)
    );

endmodule

// ===== rtl/rtd_r2t_front.sv =====
`timescale 1ns / 1ps
module rtd_r2t_front (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [rtd_r2t_pkg::WORD_W-1:0]      s_rtd_word,
    input  logic [rtd_r2t_pkg::CFG_W-1:0]       r_reference_i,
    input  logic                                pop_i,
    output logic                                q_valid_o,
    output rtd_r2t_pkg::q_entry_t               q_entry_o
);
    import rtd_r2t_pkg::*;

    q_entry_t   entry_mem [2];
    q_entry_t   entry_in;
    logic [1:0] count_reg;
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic       push;
    logic       pop;

    // classify and form code * r_reference
    assign entry_in.fault = s_rtd_word[0];
    assign entry_in.num   = NUM_W'(s_rtd_word[WORD_W-1:1]) * NUM_W'(r_reference_i);

    assign s_ready   = (count_reg != 2'd2);
    assign push      = s_valid && s_ready;
    assign q_valid_o = (count_reg != 2'd0);
    assign pop       = pop_i && q_valid_o;
    assign q_entry_o = entry_mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg  <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 2'd1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_mem[wr_ptr_reg] <= entry_in;
        end
    end

endmodule

// ===== rtl/rtd_r2t_divider.sv =====
`timescale 1ns / 1ps
module rtd_r2t_divider (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  rtd_r2t_pkg::div_req_t            req_i,
    output logic                             done_o,
    output logic [rtd_r2t_pkg::DIV_W-1:0]    quot_o
);
    import rtd_r2t_pkg::*;

    localparam logic [3:0] STEP_LAST = 4'(DIV_W / 2 - 1);

    logic              busy_reg;
    logic              done_reg;
    logic [3:0]        cnt_reg;
    logic [DREM_W-1:0] rem_reg;
    logic [DIV_W-1:0]  dvd_reg;
    logic [DIV_W-1:0]  quot_reg;
    logic [DREM_W-1:0] dvs_reg;

    logic [DREM_W:0]   r1, r2;
    logic [DREM_W-1:0] rem1, rem2;
    logic              b1, b2;

    // two restoring steps per cycle
    always_comb begin
        r1   = {rem_reg, dvd_reg[DIV_W-1]};
        b1   = (r1 >= {1'b0, dvs_reg});
        rem1 = b1 ? DREM_W'(r1 - {1'b0, dvs_reg}) : r1[DREM_W-1:0];
        r2   = {rem1, dvd_reg[DIV_W-2]};
        b2   = (r2 >= {1'b0, dvs_reg});
        rem2 = b2 ? DREM_W'(r2 - {1'b0, dvs_reg}) : r2[DREM_W-1:0];
    end

    assign done_o = done_reg;
    assign quot_o = quot_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 4'd0;
        end else begin
            done_reg <= 1'b0;
            if (req_i.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= 4'd0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 4'd1;
                if (cnt_reg == STEP_LAST) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req_i.start) begin
            rem_reg  <= req_i.rem0;
            dvd_reg  <= req_i.dividend;
            dvs_reg  <= req_i.divisor;
            quot_reg <= '0;
        end else if (busy_reg) begin
            rem_reg  <= rem2;
            dvd_reg  <= {dvd_reg[DIV_W-3:0], 2'b00};
            quot_reg <= {quot_reg[DIV_W-3:0], b1, b2};
        end
    end

endmodule

// ===== rtl/rtd_r2t_sqrt.sv =====
`timescale 1ns / 1ps
module rtd_r2t_sqrt (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  rtd_r2t_pkg::sqrt_req_t            req_i,
    output logic                              done_o,
    output logic [rtd_r2t_pkg::ROOT_W-1:0]    root_o
);
    import rtd_r2t_pkg::*;

    localparam logic [3:0] STEP_LAST = 4'd13;

    logic                busy_reg;
    logic                done_reg;
    logic [3:0]          cnt_reg;
    logic [SQ_ARG_W-1:0] v_reg;
    logic [SQ_W-1:0]     r_reg;
    logic [SQ_W-1:0]     b_reg;

    logic [SQ_W-1:0]     rb1, rb2, r1, r2, bh;
    logic [SQ_ARG_W-1:0] v1, v2;
    logic                ge1, ge2;

    // two digit-by-digit root steps per cycle
    always_comb begin
        rb1 = r_reg + b_reg;
        ge1 = ({2'b00, v_reg} >= rb1);
        v1  = ge1 ? SQ_ARG_W'({2'b00, v_reg} - rb1) : v_reg;
        r1  = ge1 ? ((r_reg >> 1) + b_reg) : (r_reg >> 1);
        bh  = b_reg >> 2;
        rb2 = r1 + bh;
        ge2 = ({2'b00, v1} >= rb2);
        v2  = ge2 ? SQ_ARG_W'({2'b00, v1} - rb2) : v1;
        r2  = ge2 ? ((r1 >> 1) + bh) : (r1 >> 1);
    end

    assign done_o = done_reg;
    assign root_o = r_reg[ROOT_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 4'd0;
        end else begin
            done_reg <= 1'b0;
            if (req_i.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= 4'd0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 4'd1;
                if (cnt_reg == STEP_LAST) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req_i.start) begin
            v_reg <= req_i.arg;
            r_reg <= '0;
            b_reg <= SQ_W'(1) << SQ_ARG_W;
        end else if (busy_reg) begin
            v_reg <= v2;
            r_reg <= r2;
            b_reg <= b_reg >> 4;
        end
    end

endmodule

// ===== rtl/rtd_r2t_back.sv =====
`timescale 1ns / 1ps
module rtd_r2t_back (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   q_valid_i,
    input  rtd_r2t_pkg::q_entry_t                  q_entry_i,
    output logic                                   q_pop_o,
    input  logic [rtd_r2t_pkg::CFG_W-1:0]          r_nominal_i,
    output rtd_r2t_pkg::div_req_t                  div_req_o,
    input  logic                                   div_done_i,
    input  logic [rtd_r2t_pkg::DIV_W-1:0]          div_quot_i,
    output rtd_r2t_pkg::sqrt_req_t                 sqrt_req_o,
    input  logic                                   sqrt_done_i,
    input  logic [rtd_r2t_pkg::ROOT_W-1:0]         sqrt_root_i,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic signed [rtd_r2t_pkg::TEMP_W-1:0]  m_temperature_centi,
    output logic                                   m_fault
);
    import rtd_r2t_pkg::*;

    bk_state_t state_reg, state_next;

    logic [NUM_W-1:0]         num_reg, num_next;
    logic [X_W-1:0]           x_reg, x_next;
    logic [PROD_W-1:0]        prod_reg, prod_next;
    logic signed [ACC_W-1:0]  acc_reg, acc_next;
    logic                     neg_reg, neg_next;
    logic [2:0]               idx_reg, idx_next;
    logic signed [TEMP_W-1:0] res_reg, res_next;
    logic                     rfault_reg, rfault_next;
    logic                     m_valid_reg;
    logic signed [TEMP_W-1:0] out_temp_reg;
    logic                     out_fault_reg;

    logic [CFG_W-1:0]         rn_eff;
    logic                     big, over, x_ge_one, out_free, out_load;
    logic [X_W-1:0]           y;
    logic [29:0]              t_val;
    logic [TERM_W-1:0]        term;
    logic [ROOT_W-1:0]        d_val;
    logic [DIV_W-1:0]         m32;
    logic [DIV_W-1:0]         rnd;
    logic signed [ACC_W-1:0]  acc_mag, sh, qq, qp;

    assign rn_eff   = (r_nominal_i == '0) ? CFG_W'(1) : r_nominal_i;
    assign big      = ({3'b000, num_reg} >= {rn_eff, 18'b0});
    assign x_ge_one = (x_reg[X_W-1:QF] != '0);
    assign y        = x_reg - {3'b001, {QF{1'b0}}};
    assign t_val    = prod_reg[57:QF];
    assign term     = TERM_W'(t_val) * TERM_W'(CVD_4B);
    assign over     = (term > CVD_A2_E16);
    assign d_val    = CVD_A_S8 - sqrt_root_i;
    assign m32      = DIV_W'(d_val) * 32'd25 + ROUND_BIAS;
    assign acc_mag  = (acc_reg < 0) ? -acc_reg : acc_reg;
    assign rnd      = acc_mag[DIV_W-1:0] + HALF_1E5;
    assign sh       = signed'({2'b00, prod_reg[PROD_W-1:QF]});
    // quotients of the reciprocal multiplies
    assign qq       = signed'({9'b0, prod_reg[PROD_W-1:QDIV_SH]});
    assign qp       = signed'({13'b0, prod_reg[PROD_W-1:PDIV_SH]});
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:    if (q_valid_i) state_next = q_entry_i.fault ? ST_DONE : ST_RANGE;
            ST_RANGE:   state_next = big ? ST_DONE : ST_DIV_X;
            ST_DIV_X:   if (div_done_i) state_next = ST_BRANCH;
            ST_BRANCH:  state_next = x_ge_one ? ST_Q_TERM : ST_P_MUL;
            ST_Q_TERM:  state_next = over ? ST_DONE : ST_SQRT;
            ST_SQRT:    if (sqrt_done_i) state_next = ST_DIV_Q;
            ST_DIV_Q:   state_next = ST_Q_QUOT;
            ST_Q_QUOT:  state_next = ST_DONE;
            ST_P_MUL:   state_next = ST_P_ADD;
            ST_P_ADD:   state_next = (idx_reg == POLY_LAST) ? ST_P_ROUND : ST_P_MUL;
            ST_P_ROUND: state_next = ST_DIV_P;
            ST_DIV_P:   state_next = ST_P_QUOT;
            ST_P_QUOT:  state_next = ST_DONE;
            ST_DONE:    if (out_free) state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        num_next    = num_reg;
        x_next      = x_reg;
        prod_next   = prod_reg;
        acc_next    = acc_reg;
        neg_next    = neg_reg;
        idx_next    = idx_reg;
        res_next    = res_reg;
        rfault_next = rfault_reg;
        q_pop_o     = 1'b0;
        div_req_o   = '0;
        sqrt_req_o  = '0;
        out_load    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (q_valid_i) begin
                    q_pop_o     = 1'b1;
                    num_next    = q_entry_i.num;
                    rfault_next = q_entry_i.fault;
                    res_next    = '0;
                end
            end
            ST_RANGE: begin
                if (big) begin
                    res_next = TEMP_MAX;
                end else begin
                    // x = num * 2^13 / r_nominal, upper bits preloaded as remainder
                    div_req_o.start    = 1'b1;
                    div_req_o.rem0     = DREM_W'(num_reg[NUM_W-1:19]);
                    div_req_o.dividend = {num_reg[18:0], 13'b0};
                    div_req_o.divisor  = rn_eff;
                end
            end
            ST_DIV_X: begin
                if (div_done_i) begin
                    x_next = div_quot_i[X_W-1:0];
                end
            end
            ST_BRANCH: begin
                if (x_ge_one) begin
                    prod_next = PROD_W'({27'b0, y} * {31'b0, SCALE_1E8});
                end else begin
                    acc_next = poly_coef(3'd0);
                    idx_next = 3'd1;
                end
            end
            ST_Q_TERM: begin
                if (over) begin
                    res_next = TEMP_MAX;
                end else begin
                    sqrt_req_o.start = 1'b1;
                    sqrt_req_o.arg   = {CVD_A2_E16 - term, 16'b0};
                end
            end
            ST_SQRT: begin
                // (25 * d + 3696) / 32, still to be divided by 231
                if (sqrt_done_i) begin
                    acc_next = signed'({7'b0, m32[DIV_W-1:5]});
                end
            end
            ST_DIV_Q: begin
                prod_next = {33'b0, acc_reg[26:0]} * {32'b0, RECIP_231};
            end
            ST_Q_QUOT: begin
                res_next = clamp_temp(qq);
            end
            ST_P_MUL: begin
                neg_next  = (acc_reg < 0);
                prod_next = {28'b0, acc_mag[DIV_W-1:0]} * {32'b0, x_reg[QF-1:0]};
            end
            ST_P_ADD: begin
                acc_next = (neg_reg ? -sh : sh) + poly_coef(idx_reg);
                idx_next = idx_reg + 3'd1;
            end
            ST_P_ROUND: begin
                // divide by 100000 as a shift by 5, then by 3125
                neg_next = (acc_reg < 0);
                acc_next = signed'({7'b0, rnd[DIV_W-1:5]});
            end
            ST_DIV_P: begin
                prod_next = {33'b0, acc_reg[26:0]} * {32'b0, RECIP_3125};
            end
            ST_P_QUOT: begin
                res_next = clamp_temp(neg_reg ? -qp : qp);
            end
            ST_DONE: begin
                out_load = out_free;
            end
            default: begin
                out_load = 1'b0;
            end
        endcase
    end

    assign m_valid             = m_valid_reg;
    assign m_temperature_centi = out_temp_reg;
    assign m_fault             = out_fault_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        num_reg    <= num_next;
        x_reg      <= x_next;
        prod_reg   <= prod_next;
        acc_reg    <= acc_next;
        neg_reg    <= neg_next;
        idx_reg    <= idx_next;
        res_reg    <= res_next;
        rfault_reg <= rfault_next;
        if (out_load) begin
            out_temp_reg  <= res_reg;
            out_fault_reg <= rfault_reg;
        end
    end

endmodule

// ===== sim/rtd_resistance_to_temperature_test.sv =====
`timescale 1ns / 1ps
module rtd_resistance_to_temperature_test;
    import rtd_r2t_pkg::*;

    // fixed-point constants of the inverse callendar-van dusen solve
    localparam int                QBITS     = 28;
    localparam longint unsigned   Q_UNIT    = 64'd1 << QBITS;
    localparam longint unsigned   ROOT_ARG  = 64'd152748088900;
    localparam longint unsigned   FOUR_B    = 64'd231;
    localparam longint unsigned   A_SCALED  = 64'd100052480;
    localparam longint unsigned   QUAD_DIV  = 64'd59136;
    localparam longint            T_LOW     = -25000;
    localparam longint            T_HIGH    = 100000;
    localparam logic [WORD_W-1:0] FAULT_BIT = 16'h0001;

    typedef struct {
        logic signed [TEMP_W-1:0] temp;
        logic                     flt;
    } reading_t;

    logic                     aclk = 1'b0;
    logic                     aresetn = 1'b0;
    logic                     s_valid = 1'b0;
    logic                     s_ready;
    logic [WORD_W-1:0]        s_rtd_word = '0;
    logic                     m_valid;
    logic                     m_ready = 1'b0;
    logic signed [TEMP_W-1:0] m_temperature_centi;
    logic                     m_fault;
    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    logic [CFG_IDX_W-1:0]     cfg_index = '0;
    logic [CFG_W-1:0]         cfg_data = '0;

    // local copy of the two registers
    logic [CFG_W-1:0] nominal_ohm;
    logic [CFG_W-1:0] reference_ohm;

    reading_t pending_readings[$];
    int       error_count = 0;
    int       burst_left = 0;

    rtd_resistance_to_temperature DUT (.*);

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // ---------------- predictor ----------------

    function automatic longint unsigned root_floor(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'h4000_0000_0000_0000;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    // signed accumulator times q28 x, truncated toward zero
    function automatic longint times_x(longint acc, longint unsigned x);
        longint unsigned m;
        m = (acc < 0) ? longint'(-acc) : longint'(acc);
        m = (m * x) >> QBITS;
        return (acc < 0) ? -longint'(m) : longint'(m);
    endfunction

    function automatic longint clamp_centi(longint t);
        if (t < T_LOW) return T_LOW;
        if (t > T_HIGH) return T_HIGH;
        return t;
    endfunction

    function automatic longint ratio_to_centi(longint unsigned code);
        longint unsigned rn, num, den, x, y, t, term, s;
        longint          acc;
        longint          coef[6];
        coef = '{64'sd1524300, -64'sd2818300, -64'sd48260000, 64'sd258590000,
                 64'sd2222800000, -64'sd2420200000};
        rn   = (nominal_ohm == 0) ? 1 : nominal_ohm;
        num  = code * reference_ohm;
        den  = 64'd32768 * rn;
        x    = ((num / den) << QBITS) + (((num % den) << QBITS) / den);
        if (x >= Q_UNIT) begin
            // quadratic branch, root argument in units of 1e-16
            y = x - Q_UNIT;
            if (y >= (64'd7 << QBITS)) return T_HIGH;
            t    = (64'd100000000 * y) >> QBITS;
            term = FOUR_B * t;
            if (term > ROOT_ARG) return T_HIGH;
            s = root_floor((ROOT_ARG - term) << 16);
            return clamp_centi(longint'((64'd200 * (A_SCALED - s) + QUAD_DIV / 2) / QUAD_DIV));
        end
        // below r0: fifth-order polynomial by horner, round half away from zero
        acc = coef[0];
        for (int i = 1; i < 6; i++) acc = times_x(acc, x) + coef[i];
        if (acc < 0) return clamp_centi(-((-acc + 50000) / 100000));
        return clamp_centi((acc + 50000) / 100000);
    endfunction

    function automatic reading_t predict_reading(logic [WORD_W-1:0] w);
        reading_t r;
        r.flt  = (w & FAULT_BIT) != 0;
        r.temp = r.flt ? '0 : TEMP_W'(ratio_to_centi(longint'(w >> 1)));
        return r;
    endfunction

    // ---------------- result checker ----------------

    always @(posedge aclk) begin
        reading_t e;
        if (aresetn && m_valid && m_ready) begin
            if (pending_readings.size() == 0) begin
                $error("unexpected item: temperature_centi %0d fault %0b",
                       m_temperature_centi, m_fault);
                error_count++;
            end else begin
                e = pending_readings.pop_front();
                if (m_temperature_centi !== e.temp) begin
                    $error("temperature_centi expected %0d actual %0d",
                           e.temp, m_temperature_centi);
                    error_count++;
                end
                if (m_fault !== e.flt) begin
                    $error("fault expected %0b actual %0b", e.flt, m_fault);
                    error_count++;
                end
            end
        end
    end

    // receiver stall pattern: phases of always-ready, coin flip and heavy stall
    always @(posedge aclk) begin
        int unsigned phase;
        phase = 32'(($time / 400) % 3);
        if (phase == 0) m_ready <= 1'b1;
        else if (phase == 1) m_ready <= $urandom_range(1, 0);
        else m_ready <= ($urandom_range(7, 0) == 0);
    end

    // ---------------- stimulus helpers ----------------

    // one item; sender runs in bursts with random gaps between them
    task automatic send_word(logic [WORD_W-1:0] w);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(12, 1);
            gap = $urandom_range(3) == 0 ? 0 : $urandom_range(60, 1);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_valid    <= 1'b1;
        s_rtd_word <= w;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_readings.push_back(predict_reading(w));
    endtask

    // hold the sender until every pending item is back, then let the back end settle
    task automatic drain_block();
        s_valid <= 1'b0;
        burst_left = 0;
        @(posedge aclk);
        while (pending_readings.size() != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
    endtask

    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
        drain_block();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        if (idx == CFG_R_NOMINAL) nominal_ohm = value;
        else reference_ohm = value;
    endtask

    task automatic set_resistors(logic [CFG_W-1:0] rn, logic [CFG_W-1:0] rr);
        write_register(CFG_R_NOMINAL, rn);
        write_register(CFG_R_REFERENCE, rr);
    endtask

    function automatic logic [WORD_W-1:0] random_word();
        logic [WORD_W-1:0] w;
        w = WORD_W'($urandom);
        if ($urandom_range(7, 0) != 0) w &= ~FAULT_BIT;
        return w;
    endfunction

    // ---------------- tests ----------------

    // fault words with extreme codes, then clean extremes at reset values
    task automatic test_reset_extremes();
        send_word(16'h0001);
        send_word(16'hFFFF);
        send_word(16'h0000);
        send_word(16'h0002);
        send_word(16'hFFFE);
        send_word(16'(7620) << 1);    // just under r0
        send_word(16'(7621) << 1);    // just over r0
        send_word(16'(15000) << 1);
    endtask

    // x near 7.6: root argument goes negative
    task automatic test_root_limits();
        set_resistors(20'd100, 20'd800);
        send_word(16'(31000) << 1);
        send_word(16'(31539) << 1);
        send_word(16'(32000) << 1);
        send_word(16'hFFFE);
        send_word(16'(4096) << 1);
    endtask

    // zero nominal counts as one; zero reference gives x = 0
    task automatic test_zero_registers();
        set_resistors(20'd0, 20'd100);
        send_word(16'h0010);
        send_word(16'hFFFE);
        set_resistors(20'hFFFFF, 20'd0);
        send_word(16'hFFFE);
        send_word(16'h1235);
        set_resistors(20'hFFFFF, 20'hFFFFF);
        send_word(16'hFFFE);
        send_word(16'h4000);
    endtask

    task automatic test_random_phase(logic [CFG_W-1:0] rn, logic [CFG_W-1:0] rr, int count);
        set_resistors(rn, rr);
        for (int i = 0; i < count; i++) begin
            send_word(random_word());
            // mid-phase pause until everything in flight is back
            if (i == count / 2) drain_block();
        end
    endtask

    initial begin
        nominal_ohm   = R_NOMINAL_RST;
        reference_ohm = R_REFERENCE_RST;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_extremes();
        test_root_limits();
        test_zero_registers();
        test_random_phase(20'd10000, 20'd43000, 400);   // pt100, 430 ohm reference
        test_random_phase(20'd100000, 20'd400000, 300); // pt1000
        test_random_phase(20'd10000, 20'd20000, 300);
        test_random_phase(20'd100, 20'd1000000, 150);   // mostly saturated high
        test_random_phase(20'd1000000, 20'd100, 150);   // x near zero, bottom of the polynomial range
        test_random_phase(20'($urandom_range(1000000, 100)),
                          20'($urandom_range(1000000, 100)), 300);

        drain_block();
        if (error_count == 0) begin
            $display("rtd_resistance_to_temperature_test passed");
        end else begin
            $display("rtd_resistance_to_temperature_test failed");
        end
        $finish;
    end

    initial begin
        #4000000;
        $display("rtd_resistance_to_temperature_test failed");
        $finish;
    end

endmodule
